// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the velocity PID block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge outside reset.
`define VPID_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Checked on every edge, reset included.
`define VPID_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// File: design/vpid_pkg.sv
// ----------------------------------------------------------------------------
// vpid_pkg
// Types, register indexes and microcode program of the velocity PID block.
// ----------------------------------------------------------------------------
package vpid_pkg;

  localparam int STEP_BITS = 5;
  typedef logic [STEP_BITS-1:0] step_t;

  typedef enum logic [2:0] {
    CFG_GAIN_P          = 3'd0,
    CFG_INTEGRAL_TIME   = 3'd1,
    CFG_DERIVATIVE_TIME = 3'd2,
    CFG_OUT_MIN         = 3'd3,
    CFG_OUT_MAX         = 3'd4,
    CFG_OUT_ZERO        = 3'd5,
    CFG_BAND_LOW        = 3'd6,
    CFG_BAND_HIGH       = 3'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ADD,
    OP_SUB,
    OP_MAX,
    OP_MIN,
    OP_BAND,
    OP_MUL,
    OP_DIV,
    OP_TAKE,
    OP_COMMIT
  } op_t;

  typedef enum logic [3:0] {
    SRC_TGT,
    SRC_MEAS,
    SRC_DT,
    SRC_ERR,
    SRC_LERR,
    SRC_M1,
    SRC_M2,
    SRC_ACC,
    SRC_X,
    SRC_Y,
    SRC_Z,
    SRC_GAIN,
    SRC_TI,
    SRC_TD,
    SRC_OMIN,
    SRC_OMAX
  } src_t;

  typedef enum logic [2:0] {
    DST_NONE,
    DST_ERR,
    DST_X,
    DST_Y,
    DST_Z
  } dst_t;

  typedef enum logic [2:0] {
    JC_NEVER,
    JC_NO_INPUT,
    JC_UNIT_BUSY,
    JC_ERR_BIG,
    JC_OUT_FULL
  } jcond_t;

  typedef struct packed {
    op_t    op;
    src_t   a;
    src_t   b;
    dst_t   dst;
    jcond_t jc;
    step_t  target;
    logic   take_in;
    logic   wrap;
  } ctrl_t;

  // request from the sequencer to the multiply/divide unit
  typedef struct packed {
    logic start;
    logic is_div;
  } unit_req_t;

  // program addresses
  localparam step_t S_IDLE     = 5'd0;
  localparam step_t S_ERR      = 5'd1;
  localparam step_t S_DERR     = 5'd2;
  localparam step_t S_P_MUL    = 5'd3;
  localparam step_t S_P_TAKE   = 5'd4;
  localparam step_t S_KPDT_MUL = 5'd5;
  localparam step_t S_KPDT_TK  = 5'd6;
  localparam step_t S_KI_DIV   = 5'd7;
  localparam step_t S_KI_TAKE  = 5'd8;
  localparam step_t S_I_MUL    = 5'd9;
  localparam step_t S_I_TAKE   = 5'd10;
  localparam step_t S_PI_ADD   = 5'd11;
  localparam step_t S_D2_A     = 5'd12;
  localparam step_t S_D2_B     = 5'd13;
  localparam step_t S_D2_C     = 5'd14;
  localparam step_t S_KPTD_MUL = 5'd15;
  localparam step_t S_KPTD_TK  = 5'd16;
  localparam step_t S_KD_DIV   = 5'd17;
  localparam step_t S_KD_TAKE  = 5'd18;
  localparam step_t S_D_MUL    = 5'd19;
  localparam step_t S_D_TAKE   = 5'd20;
  localparam step_t S_DU       = 5'd21;
  localparam step_t S_ACC      = 5'd22;
  localparam step_t S_CLAMP_LO = 5'd23;
  localparam step_t S_CLAMP_HI = 5'd24;
  localparam step_t S_BAND     = 5'd25;
  localparam step_t S_COMMIT   = 5'd26;

  function automatic ctrl_t mk(input op_t op, input src_t a, input src_t b,
                               input dst_t dst, input jcond_t jc,
                               input step_t target, input logic take_in,
                               input logic wrap);
    ctrl_t w;
    w.op      = op;
    w.a       = a;
    w.b       = b;
    w.dst     = dst;
    w.jc      = jc;
    w.target  = target;
    w.take_in = take_in;
    w.wrap    = wrap;
    return w;
  endfunction

  // One control word per step. While its condition holds a step jumps to its
  // target (itself, or commit); else advance, or wrap to idle after the commit.
  function automatic ctrl_t rom_word(input step_t s);
    ctrl_t w;
    unique case (s)
      S_IDLE:     w = mk(OP_NOP, SRC_X, SRC_X, DST_NONE, JC_NO_INPUT, S_IDLE, 1'b1, 1'b0);
      S_ERR:      w = mk(OP_SUB, SRC_TGT, SRC_MEAS, DST_ERR, JC_NEVER, S_IDLE, 1'b0, 1'b0);
      S_DERR:     w = mk(OP_SUB, SRC_ERR, SRC_LERR, DST_X, JC_NEVER, S_IDLE, 1'b0, 1'b0);
      S_P_MUL:    w = mk(OP_MUL, SRC_GAIN, SRC_X, DST_NONE, JC_NEVER, S_IDLE, 1'b0, 1'b0);
      S_P_TAKE:   w = mk(OP_TAKE, SRC_X, SRC_X, DST_X, JC_UNIT_BUSY, S_P_TAKE, 1'b0, 1'b0);
      S_KPDT_MUL: w = mk(OP_MUL, SRC_GAIN, SRC_DT, DST_NONE, JC_NEVER, S_IDLE, 1'b0, 1'b0);
      S_KPDT_TK:  w = mk(OP_TAKE, SRC_Y, SRC_Y, DST_Y, JC_UNIT_BUSY, S_KPDT_TK, 1'b0, 1'b0);
      S_KI_DIV:   w = mk(OP_DIV, SRC_Y, SRC_TI, DST_NONE, JC_NEVER, S_IDLE, 1'b0, 1'b0);
      S_KI_TAKE:  w = mk(OP_TAKE, SRC_Y, SRC_Y, DST_Y, JC_UNIT_BUSY, S_KI_TAKE, 1'b0, 1'b0);
      S_I_MUL:    w = mk(OP_MUL, SRC_Y, SRC_ERR, DST_NONE, JC_NEVER, S_IDLE, 1'b0, 1'b0);
      S_I_TAKE:   w = mk(OP_TAKE, SRC_Y, SRC_Y, DST_Y, JC_UNIT_BUSY, S_I_TAKE, 1'b0, 1'b0);
      S_PI_ADD:   w = mk(OP_ADD, SRC_X, SRC_Y, DST_X, JC_NEVER, S_IDLE, 1'b0, 1'b0);
      S_D2_A:     w = mk(OP_SUB, SRC_MEAS, SRC_M1, DST_Y, JC_NEVER, S_IDLE, 1'b0, 1'b0);
      S_D2_B:     w = mk(OP_SUB, SRC_Y, SRC_M1, DST_Y, JC_NEVER, S_IDLE, 1'b0, 1'b0);
      S_D2_C:     w = mk(OP_ADD, SRC_Y, SRC_M2, DST_Y, JC_NEVER, S_IDLE, 1'b0, 1'b0);
      S_KPTD_MUL: w = mk(OP_MUL, SRC_GAIN, SRC_TD, DST_NONE, JC_NEVER, S_IDLE, 1'b0, 1'b0);
      S_KPTD_TK:  w = mk(OP_TAKE, SRC_Z, SRC_Z, DST_Z, JC_UNIT_BUSY, S_KPTD_TK, 1'b0, 1'b0);
      S_KD_DIV:   w = mk(OP_DIV, SRC_Z, SRC_DT, DST_NONE, JC_NEVER, S_IDLE, 1'b0, 1'b0);
      S_KD_TAKE:  w = mk(OP_TAKE, SRC_Z, SRC_Z, DST_Z, JC_UNIT_BUSY, S_KD_TAKE, 1'b0, 1'b0);
      S_D_MUL:    w = mk(OP_MUL, SRC_Z, SRC_Y, DST_NONE, JC_NEVER, S_IDLE, 1'b0, 1'b0);
      S_D_TAKE:   w = mk(OP_TAKE, SRC_Y, SRC_Y, DST_Y, JC_UNIT_BUSY, S_D_TAKE, 1'b0, 1'b0);
      S_DU:       w = mk(OP_SUB, SRC_X, SRC_Y, DST_X, JC_NEVER, S_IDLE, 1'b0, 1'b0);
      S_ACC:      w = mk(OP_ADD, SRC_ACC, SRC_X, DST_X, JC_NEVER, S_IDLE, 1'b0, 1'b0);
      S_CLAMP_LO: w = mk(OP_MAX, SRC_X, SRC_OMIN, DST_X, JC_NEVER, S_IDLE, 1'b0, 1'b0);
      S_CLAMP_HI: w = mk(OP_MIN, SRC_X, SRC_OMAX, DST_X, JC_ERR_BIG, S_COMMIT, 1'b0, 1'b0);
      S_BAND:     w = mk(OP_BAND, SRC_X, SRC_X, DST_X, JC_NEVER, S_IDLE, 1'b0, 1'b0);
      S_COMMIT:   w = mk(OP_COMMIT, SRC_X, SRC_X, DST_NONE, JC_OUT_FULL, S_COMMIT, 1'b0, 1'b1);
      default:    w = mk(OP_NOP, SRC_X, SRC_X, DST_NONE, JC_NEVER, S_IDLE, 1'b0, 1'b1);
    endcase
    return w;
  endfunction

endpackage

// File: design/velocity_pid_with_deadzone.sv
// ----------------------------------------------------------------------------
// velocity_pid_with_deadzone
// Incremental PID with output clamp and dead band, run by a microcoded
// sequencer over a saturating ALU and a bit-serial multiply/divide unit.
// ----------------------------------------------------------------------------
// The run time of an item is set by five serial products and two serial quotients;
//   the next item is taken only once the program is back at the idle step.
// The result is valid once the commit step has run; a large error skips the band.
// A new item is taken while the result waits; the commit step holds until free.
// Reset: synchronous; clears history and output, loads register defaults, idles.
`include "assert_macros.svh"

module velocity_pid_with_deadzone #(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] target,
  input  logic signed [31:0] measured,
  input  logic [30:0]        step_time,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] drive
);

  localparam int W  = WORD_BITS;
  localparam int IW = (W > 32) ? W : 32;
  localparam logic signed [W-1:0]  WMAX    = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  WMIN    = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [IW:0]   WMAX_X  = {{(IW-W+2){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [IW:0]   WMIN_X  = {{(IW-W+2){1'b1}}, {(W-1){1'b0}}};
  localparam logic signed [W-1:0]  ONE_W   = (FRAC_BITS < W - 1) ? (W'(1) << FRAC_BITS) : WMAX;
  localparam logic signed [W-1:0]  MONE_W  = (FRAC_BITS < W - 1) ? -(W'(1) << FRAC_BITS) : WMIN;
  localparam int                   SMALL_ERR = ((1 << FRAC_BITS) + 50) / 100;
  localparam logic signed [IW:0]   SMALL_X = (IW+1)'(SMALL_ERR);

  // configuration
  logic signed [W-1:0] r_gain, r_ti, r_td, r_omin, r_omax, r_ozero, r_blow, r_bhigh;
  // history and output level
  logic signed [W-1:0] r_lerr, r_m1, r_m2, r_acc;
  // working registers
  logic signed [W-1:0] r_tgt, r_meas, r_dt, r_err, r_x, r_y, r_z;

  vpid_pkg::step_t     pc;
  vpid_pkg::step_t     pc_next;
  vpid_pkg::ctrl_t     ctrl;
  vpid_pkg::unit_req_t unit_req;
  logic                unit_busy;
  logic signed [W-1:0] unit_result;

  logic signed [W-1:0] a_val, b_val, alu_val;
  logic signed [W:0]   sum;
  logic signed [IW:0]  err_x;
  logic                err_big;
  logic                out_full;
  logic                jump;
  logic                dst_we;
  logic                commit;
  logic signed [IW-1:0] x_ext;

  function automatic logic signed [W-1:0] sat_word(input logic signed [31:0] v);
    logic signed [IW:0] vx;
    vx = {{(IW+1-32){v[31]}}, v};
    if (vx > WMAX_X) begin
      return WMAX;
    end else if (vx < WMIN_X) begin
      return WMIN;
    end
    return vx[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] sat_sum(input logic signed [W:0] s);
    if (s[W] != s[W-1]) begin
      return s[W] ? WMIN : WMAX;
    end
    return s[W-1:0];
  endfunction

  // control word decode and datapath selection
  always_comb begin
    ctrl     = vpid_pkg::rom_word(pc);
    // take nothing while reset is held
    in_ready = ctrl.take_in && !rst;
    out_full = out_valid && !out_ready;
    err_x    = {{(IW+1-W){r_err[W-1]}}, r_err};
    err_big  = !((err_x < SMALL_X) && (err_x > -SMALL_X));

    case (ctrl.a)
      vpid_pkg::SRC_TGT:  a_val = r_tgt;
      vpid_pkg::SRC_MEAS: a_val = r_meas;
      vpid_pkg::SRC_DT:   a_val = r_dt;
      vpid_pkg::SRC_ERR:  a_val = r_err;
      vpid_pkg::SRC_LERR: a_val = r_lerr;
      vpid_pkg::SRC_M1:   a_val = r_m1;
      vpid_pkg::SRC_M2:   a_val = r_m2;
      vpid_pkg::SRC_ACC:  a_val = r_acc;
      vpid_pkg::SRC_X:    a_val = r_x;
      vpid_pkg::SRC_Y:    a_val = r_y;
      vpid_pkg::SRC_Z:    a_val = r_z;
      vpid_pkg::SRC_GAIN: a_val = r_gain;
      vpid_pkg::SRC_TI:   a_val = r_ti;
      vpid_pkg::SRC_TD:   a_val = r_td;
      vpid_pkg::SRC_OMIN: a_val = r_omin;
      default:            a_val = r_omax;
    endcase

    case (ctrl.b)
      vpid_pkg::SRC_TGT:  b_val = r_tgt;
      vpid_pkg::SRC_MEAS: b_val = r_meas;
      vpid_pkg::SRC_DT:   b_val = r_dt;
      vpid_pkg::SRC_ERR:  b_val = r_err;
      vpid_pkg::SRC_LERR: b_val = r_lerr;
      vpid_pkg::SRC_M1:   b_val = r_m1;
      vpid_pkg::SRC_M2:   b_val = r_m2;
      vpid_pkg::SRC_ACC:  b_val = r_acc;
      vpid_pkg::SRC_X:    b_val = r_x;
      vpid_pkg::SRC_Y:    b_val = r_y;
      vpid_pkg::SRC_Z:    b_val = r_z;
      vpid_pkg::SRC_GAIN: b_val = r_gain;
      vpid_pkg::SRC_TI:   b_val = r_ti;
      vpid_pkg::SRC_TD:   b_val = r_td;
      vpid_pkg::SRC_OMIN: b_val = r_omin;
      default:            b_val = r_omax;
    endcase

    if (ctrl.op == vpid_pkg::OP_SUB) begin
      sum = {a_val[W-1], a_val} - {b_val[W-1], b_val};
    end else begin
      sum = {a_val[W-1], a_val} + {b_val[W-1], b_val};
    end

    unique case (ctrl.op) inside
      vpid_pkg::OP_ADD,
      vpid_pkg::OP_SUB:  alu_val = sat_sum(sum);
      vpid_pkg::OP_MAX:  alu_val = (a_val < b_val) ? b_val : a_val;
      vpid_pkg::OP_MIN:  alu_val = (a_val > b_val) ? b_val : a_val;
      // rest level when strictly inside the band
      vpid_pkg::OP_BAND: alu_val = ((r_x > r_blow) && (r_x < r_bhigh)) ? r_ozero : r_x;
      vpid_pkg::OP_TAKE: alu_val = unit_result;
      default:           alu_val = a_val;
    endcase

    unit_req.start  = (ctrl.op == vpid_pkg::OP_MUL) || (ctrl.op == vpid_pkg::OP_DIV);
    unit_req.is_div = (ctrl.op == vpid_pkg::OP_DIV);

    dst_we = (ctrl.dst != vpid_pkg::DST_NONE) &&
             !((ctrl.op == vpid_pkg::OP_TAKE) && unit_busy);
    commit = (ctrl.op == vpid_pkg::OP_COMMIT) && !out_full;
    x_ext  = IW'(r_x);
  end

  // step counter
  always_comb begin
    unique case (ctrl.jc)
      vpid_pkg::JC_NO_INPUT:  jump = !in_valid;
      vpid_pkg::JC_UNIT_BUSY: jump = unit_busy;
      vpid_pkg::JC_ERR_BIG:   jump = err_big;
      vpid_pkg::JC_OUT_FULL:  jump = out_full;
      default:                jump = 1'b0;
    endcase
    if (jump) begin
      pc_next = ctrl.target;
    end else if (ctrl.wrap) begin
      pc_next = vpid_pkg::S_IDLE;
    end else begin
      pc_next = pc + vpid_pkg::step_t'(1);
    end
  end

  vpid_muldiv #(
    .W (W),
    .F (FRAC_BITS)
  ) u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .req    (unit_req),
    .a      (a_val),
    .b      (b_val),
    .busy   (unit_busy),
    .result (unit_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= vpid_pkg::S_IDLE;
      out_valid <= 1'b0;
      r_lerr    <= '0;
      r_m1      <= '0;
      r_m2      <= '0;
      r_acc     <= '0;
      r_gain    <= ONE_W;
      r_ti      <= ONE_W;
      r_td      <= '0;
      r_omin    <= MONE_W;
      r_omax    <= ONE_W;
      r_ozero   <= '0;
      r_blow    <= '0;
      r_bhigh   <= '0;
    end else begin
      pc <= pc_next;
      if (commit) begin
        r_lerr    <= r_err;
        r_m2      <= r_m1;
        r_m1      <= r_meas;
        r_acc     <= r_x;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        unique case (vpid_pkg::cfg_reg_t'(cfg_index))
          vpid_pkg::CFG_GAIN_P:          r_gain  <= sat_word({1'b0, cfg_data[30:0]});
          vpid_pkg::CFG_INTEGRAL_TIME:   r_ti    <= sat_word({1'b0, cfg_data[30:0]});
          vpid_pkg::CFG_DERIVATIVE_TIME: r_td    <= sat_word({1'b0, cfg_data[30:0]});
          vpid_pkg::CFG_OUT_MIN:         r_omin  <= sat_word(cfg_data);
          vpid_pkg::CFG_OUT_MAX:         r_omax  <= sat_word(cfg_data);
          vpid_pkg::CFG_OUT_ZERO: begin
            // load the output level as well
            r_ozero <= sat_word(cfg_data);
            r_acc   <= sat_word(cfg_data);
          end
          vpid_pkg::CFG_BAND_LOW:        r_blow  <= sat_word(cfg_data);
          vpid_pkg::CFG_BAND_HIGH:       r_bhigh <= sat_word(cfg_data);
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      r_tgt  <= sat_word(target);
      r_meas <= sat_word(measured);
      r_dt   <= sat_word({1'b0, step_time});
    end
    if (dst_we) begin
      case (ctrl.dst)
        vpid_pkg::DST_ERR: r_err <= alu_val;
        vpid_pkg::DST_X:   r_x   <= alu_val;
        vpid_pkg::DST_Y:   r_y   <= alu_val;
        vpid_pkg::DST_Z:   r_z   <= alu_val;
        default: ;
      endcase
    end
    if (commit) begin
      drive <= x_ext[31:0];
    end
  end

  `VPID_ASSERT(a_idle_unit_free, clk, rst, in_ready |-> !unit_busy, "unit busy while idle")
  `VPID_ASSERT(a_start_when_free, clk, rst, unit_req.start |-> !unit_busy, "unit restarted while busy")
  `VPID_ASSERT(a_busy_in_take, clk, rst, unit_busy |-> (ctrl.op == vpid_pkg::OP_TAKE), "unit busy outside a take step")
  `VPID_ASSERT(a_accept_advances, clk, rst, (in_valid && in_ready) |=> (pc == vpid_pkg::S_ERR), "accepted item did not start program")

endmodule

// File: design/vpid_muldiv.sv
// ----------------------------------------------------------------------------
// vpid_muldiv
// Sign-magnitude fixed-point multiply and divide, one bit per cycle,
// truncating toward zero and saturating to the word range.
// ----------------------------------------------------------------------------
module vpid_muldiv #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  vpid_pkg::unit_req_t   req,
  input  logic signed [W-1:0]   a,
  input  logic signed [W-1:0]   b,
  output logic                  busy,
  output logic signed [W-1:0]   result
);

  localparam int NB    = W + F;
  localparam int XW    = 2 * W + F;
  localparam int CNT_W = $clog2(NB + 1);

  logic             is_div;
  logic             neg;
  logic             zero_num;
  logic [CNT_W-1:0] count;
  logic [W-1:0]     opd;
  logic [2*W-1:0]   prod;
  logic [W-1:0]     rem;
  logic [NB-1:0]    quo;

  logic [W:0]       mul_sum;
  logic [W:0]       rem_shift;
  logic [W:0]       rem_diff;
  logic             rem_ge;
  logic [XW-1:0]    mag_x;
  logic [W-1:0]     lim_w;
  logic [W-1:0]     mag_sat;

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  always_comb begin
    mul_sum   = {1'b0, prod[2*W-1:W]} + (prod[0] ? {1'b0, opd} : '0);
    rem_shift = {rem, quo[NB-1]};
    rem_diff  = rem_shift - {1'b0, opd};
    rem_ge    = rem_shift >= {1'b0, opd};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (req.start) begin
      busy  <= 1'b1;
      count <= req.is_div ? CNT_W'(NB) : CNT_W'(W);
    end else if (busy) begin
      count <= count - 1'b1;
      if (count == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      is_div   <= req.is_div;
      neg      <= a[W-1] ^ b[W-1];
      zero_num <= (a == '0);
      // multiplicand for a product, divisor for a quotient
      opd      <= req.is_div ? mag(b) : mag(a);
      prod     <= {{W{1'b0}}, mag(b)};
      rem      <= '0;
      quo      <= {mag(a), {F{1'b0}}};
    end else if (busy) begin
      if (is_div) begin
        rem <= rem_ge ? rem_diff[W-1:0] : rem_shift[W-1:0];
        quo <= {quo[NB-2:0], rem_ge};
      end else begin
        prod <= {mul_sum, prod[W-1:1]};
      end
    end
  end

  always_comb begin
    mag_x   = is_div ? XW'(quo) : XW'(prod >> F);
    lim_w   = {neg, {(W-1){~neg}}};
    mag_sat = (mag_x > XW'(lim_w)) ? lim_w : mag_x[W-1:0];
    if (zero_num) begin
      result = '0;
    end else begin
      result = neg ? $signed(~mag_sat + 1'b1) : $signed(mag_sat);
    end
  end

endmodule
